@@ rtl/mlf_pkg.sv @@
// Shared constants, codes and types of the meter list filter.
// Used by the table cells, the cell chain and the top level.
package mlf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [2:0] STAT_FORWARDED = 3'd0;
    localparam logic [2:0] STAT_LISTBLOCK = 3'd1;
    localparam logic [2:0] STAT_RATELIMIT = 3'd2;
    localparam logic [2:0] STAT_UNTRACKED = 3'd3;
    localparam logic [2:0] STAT_TICK      = 3'd4;

    localparam logic [3:0] CFG_FILTER_EN  = 4'd0;
    localparam logic [3:0] CFG_DROP_MODE  = 4'd1;
    localparam logic [3:0] CFG_RATE_EN    = 4'd2;
    localparam logic [3:0] CFG_MIN_IVAL   = 4'd3;
    localparam logic [3:0] CFG_LIST_COUNT = 4'd4;
    localparam logic [3:0] CFG_LIST_ID_A  = 4'd5;
    localparam logic [3:0] CFG_LIST_ID_B  = 4'd6;
    localparam logic [3:0] CFG_LIST_ID_C  = 4'd7;

    localparam logic [31:0] LED_LIMIT_LO  = 32'd128;
    localparam logic [31:0] LED_LIMIT_HI  = 32'd512;
    localparam logic [8:0]  LED_PERIOD_SLOW = 9'd500;
    localparam logic [8:0]  LED_PERIOD_MID  = 9'd250;
    localparam logic [8:0]  LED_PERIOD_FAST = 9'd125;
    localparam logic [3:0]  LED_FLASH_FEW   = 4'd2;
    localparam logic [3:0]  LED_FLASH_MID   = 4'd4;
    localparam logic [3:0]  LED_FLASH_MANY  = 4'd8;

    // lookup word walking down the chain of table cells
    typedef struct packed {
        logic             active;
        logic [31:0]      id;
        logic [31:0]      now;
        logic             hit;
        logic             limited;
        logic [IDX_W-1:0] hit_idx;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
    } qry_t;

    // table update broadcast to all cells
    typedef struct packed {
        logic             en;
        logic             new_entry;
        logic [IDX_W-1:0] idx;
        logic [31:0]      id;
        logic [31:0]      now;
    } wr_t;

endpackage

@@ rtl/mlf_cell.sv @@
// One table cell: holds a meter id, its last forward time and a valid bit.
// Depends on mlf_pkg for the lookup and update word types.
module mlf_cell import mlf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic [15:0]      min_interval,
    input  qry_t             qry_in,
    input  wr_t              wr,
    output qry_t             qry_out
);

    logic [31:0] id_reg;
    logic [31:0] time_reg;
    logic        valid_reg;
    qry_t        qry_reg;
    qry_t        qry_next;
    logic [31:0] elapsed;

    assign elapsed = qry_in.now - time_reg;
    assign qry_out = qry_reg;

    always_comb begin
        qry_next = qry_in;
        if (qry_in.active) begin
            if (valid_reg) begin
                if (!qry_in.hit && id_reg == qry_in.id) begin
                    qry_next.hit     = 1'b1;
                    qry_next.hit_idx = cell_idx;
                    qry_next.limited = elapsed < {16'd0, min_interval};
                end
            end else if (!qry_in.free_ok) begin
                qry_next.free_ok  = 1'b1;
                qry_next.free_idx = cell_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            qry_reg.active <= 1'b0;
        end else begin
            qry_reg <= qry_next;
            if (wr.en && wr.idx == cell_idx && wr.new_entry) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr.idx == cell_idx) begin
            time_reg <= wr.now;
            if (wr.new_entry) begin
                id_reg <= wr.id;
            end
        end
    end

endmodule

@@ rtl/mlf_chain.sv @@
// Row of table cells; a lookup word advances one cell per cycle.
// Depends on mlf_pkg and mlf_cell.
module mlf_chain import mlf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] min_interval,
    input  qry_t        qry_in,
    input  wr_t         wr,
    output qry_t        qry_out
);

    qry_t link [0:TABLE_DEPTH];

    assign link[0] = qry_in;
    assign qry_out = link[TABLE_DEPTH];

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        mlf_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cell_idx     (IDX_W'(i)),
            .min_interval (min_interval),
            .qry_in       (link[i]),
            .wr           (wr),
            .qry_out      (link[i+1])
        );
    end

endmodule

@@ rtl/meter_list_filter_rate_limiter.sv @@
// Meter frame filter with per-meter rate limit and byte statistics.
// Input words (s_*) carry a frame event or a statistics tick; each gives one
// result word on m_*. Registers are written through cfg_valid/cfg_ready with
// cfg_addr and cfg_data; the user must write them only while the block is idle,
// the block does not enforce it; cfg_ready is always high. A tick, a frame with
// filtering off, a list-blocked frame or a frame with the rate limit off goes
// from S_IDLE to S_DONE, which puts its result on m_*. A frame that needs the
// interval check first walks the chain of TABLE_DEPTH cells in S_SCAN, one cell
// per cycle. One word is in work at a time: s_ready is high while no word is in
// work, also while a result waits on m_*. When the receiver stalls, the result
// holds on m_* and the next result waits in the block until m_ready. Reset
// clears state, configuration, byte count, m_valid and all table valid bits; table
// ids, times and result data are not cleared. Depends on mlf_pkg and mlf_chain.
module meter_list_filter_rate_limiter import mlf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_meter_id,
    input  logic [31:0] s_now_seconds,
    input  logic [7:0]  s_payload_len,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_forward,
    output logic [2:0]  m_status,
    output logic [31:0] m_byte_total,
    output logic [8:0]  m_led_period_ms,
    output logic [3:0]  m_led_flashes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic        filter_en_reg;
    logic        drop_mode_reg;
    logic        rate_en_reg;
    logic [15:0] min_ival_reg;
    logic [1:0]  list_count_reg;
    logic [31:0] list_a_reg, list_b_reg, list_c_reg;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [7:0]  len_reg, len_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic [31:0] res_total_reg, res_total_next;
    logic [8:0]  res_period_reg, res_period_next;
    logic [3:0]  res_flashes_reg, res_flashes_next;
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic [31:0] m_total_reg, m_total_next;
    logic [8:0]  m_period_reg, m_period_next;
    logic [3:0]  m_flashes_reg, m_flashes_next;
    qry_t        launch_reg, launch_next;
    wr_t         wr_reg, wr_next;
    qry_t        chain_out;
    logic        listed;
    logic        add_en;
    logic [7:0]  add_len;
    logic [32:0] sum;

    mlf_chain u_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .min_interval (min_ival_reg),
        .qry_in       (launch_reg),
        .wr           (wr_reg),
        .qry_out      (chain_out)
    );

    assign s_ready         = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_forward       = (m_status_reg == STAT_FORWARDED) ||
                             (m_status_reg == STAT_UNTRACKED);
    assign m_status        = m_status_reg;
    assign m_byte_total    = m_total_reg;
    assign m_led_period_ms = m_period_reg;
    assign m_led_flashes   = m_flashes_reg;

    assign listed = (list_count_reg >= 2'd1 && s_meter_id == list_a_reg) ||
                    (list_count_reg >= 2'd2 && s_meter_id == list_b_reg) ||
                    (list_count_reg == 2'd3 && s_meter_id == list_c_reg);

    assign sum = {1'b0, byte_count_reg} + {25'd0, add_len};

    always_comb begin
        state_next         = state_reg;
        len_next           = len_reg;
        res_status_next    = res_status_reg;
        res_total_next     = res_total_reg;
        res_period_next    = res_period_reg;
        res_flashes_next   = res_flashes_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_total_next       = m_total_reg;
        m_period_next      = m_period_reg;
        m_flashes_next     = m_flashes_reg;
        launch_next        = launch_reg;
        launch_next.active = 1'b0;
        wr_next            = wr_reg;
        wr_next.en         = 1'b0;
        add_en             = 1'b0;
        add_len            = len_reg;
        byte_count_next    = byte_count_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    len_next         = s_payload_len;
                    add_len          = s_payload_len;
                    res_total_next   = '0;
                    res_period_next  = '0;
                    res_flashes_next = '0;
                    res_status_next  = STAT_FORWARDED;
                    state_next       = S_DONE;
                    launch_next      = '0;
                    launch_next.id   = s_meter_id;
                    launch_next.now  = s_now_seconds;
                    if (s_opcode) begin
                        res_status_next = STAT_TICK;
                        res_total_next  = byte_count_reg;
                        if (byte_count_reg == '0) begin
                            res_period_next  = '0;
                            res_flashes_next = '0;
                        end else if (byte_count_reg < LED_LIMIT_LO) begin
                            res_period_next  = LED_PERIOD_SLOW;
                            res_flashes_next = LED_FLASH_FEW;
                        end else if (byte_count_reg < LED_LIMIT_HI) begin
                            res_period_next  = LED_PERIOD_MID;
                            res_flashes_next = LED_FLASH_MID;
                        end else begin
                            res_period_next  = LED_PERIOD_FAST;
                            res_flashes_next = LED_FLASH_MANY;
                        end
                    end else if (!filter_en_reg) begin
                        add_en = 1'b1;
                    end else if (listed == drop_mode_reg) begin
                        res_status_next = STAT_LISTBLOCK;
                    end else begin
                        // drop mode counts before the interval check
                        add_en = drop_mode_reg || !rate_en_reg;
                        if (rate_en_reg) begin
                            launch_next.active = 1'b1;
                            state_next         = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (chain_out.active) begin
                    state_next    = S_DONE;
                    wr_next.id    = chain_out.id;
                    wr_next.now   = chain_out.now;
                    if (chain_out.hit) begin
                        wr_next.idx       = chain_out.hit_idx;
                        wr_next.new_entry = 1'b0;
                        wr_next.en        = !chain_out.limited;
                        res_status_next   = chain_out.limited ? STAT_RATELIMIT
                                                              : STAT_FORWARDED;
                    end else if (chain_out.free_ok) begin
                        wr_next.idx       = chain_out.free_idx;
                        wr_next.new_entry = 1'b1;
                        wr_next.en        = 1'b1;
                        res_status_next   = STAT_FORWARDED;
                    end else begin
                        wr_next.new_entry = 1'b0;
                        res_status_next   = STAT_UNTRACKED;
                    end
                    add_en = !drop_mode_reg &&
                             !(chain_out.hit && chain_out.limited);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_total_next   = res_total_reg;
                    m_period_next  = res_period_reg;
                    m_flashes_next = res_flashes_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_IDLE && s_valid && s_opcode) begin
            byte_count_next = '0;
        end else if (add_en) begin
            byte_count_next = sum[32] ? '1 : sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            filter_en_reg     <= 1'b0;
            drop_mode_reg     <= 1'b0;
            rate_en_reg       <= 1'b0;
            min_ival_reg      <= '0;
            list_count_reg    <= '0;
            list_a_reg        <= '0;
            list_b_reg        <= '0;
            list_c_reg        <= '0;
            byte_count_reg    <= '0;
            m_valid_reg       <= 1'b0;
            launch_reg.active <= 1'b0;
            wr_reg.en         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            m_valid_reg    <= m_valid_next;
            launch_reg     <= launch_next;
            wr_reg         <= wr_next;
            if (cfg_valid) begin
                case (cfg_addr)
                    CFG_FILTER_EN:  filter_en_reg  <= cfg_data[0];
                    CFG_DROP_MODE:  drop_mode_reg  <= cfg_data[0];
                    CFG_RATE_EN:    rate_en_reg    <= cfg_data[0];
                    CFG_MIN_IVAL:   min_ival_reg   <= cfg_data[15:0];
                    CFG_LIST_COUNT: list_count_reg <= cfg_data[1:0];
                    CFG_LIST_ID_A:  list_a_reg     <= cfg_data;
                    CFG_LIST_ID_B:  list_b_reg     <= cfg_data;
                    CFG_LIST_ID_C:  list_c_reg     <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg         <= len_next;
        res_status_reg  <= res_status_next;
        res_total_reg   <= res_total_next;
        res_period_reg  <= res_period_next;
        res_flashes_reg <= res_flashes_next;
        m_status_reg    <= m_status_next;
        m_total_reg     <= m_total_next;
        m_period_reg    <= m_period_next;
        m_flashes_reg   <= m_flashes_next;
    end

endmodule

@@ bench/tb_meter_list_filter_rate_limiter.sv @@
`timescale 1ns / 100ps
// Testbench of meter_list_filter_rate_limiter: random bursts of frame and tick words
// against a cycle-free prediction of list filter, interval table and byte statistics.
// Depends on mlf_pkg and the RTL of the block; needs no other file.
module tb_meter_list_filter_rate_limiter import mlf_pkg::*; ();

    localparam int  RUN_LIMIT    = 800000;
    localparam int  RANDOM_ITEMS = 1550;
    localparam int  PHASES       = 10;
    localparam int  POOL_SIZE    = 24;
    localparam logic OP_FRAME    = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef struct {
        logic        opcode;
        logic [31:0] meter_id;
        logic [31:0] now_seconds;
        logic [7:0]  payload_len;
    } frame_word_t;

    typedef struct {
        logic        forward;
        logic [2:0]  status;
        logic [31:0] byte_total;
        logic [8:0]  led_period_ms;
        logic [3:0]  led_flashes;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = 1'b0;
    logic [31:0] s_meter_id = '0;
    logic [31:0] s_now_seconds = '0;
    logic [7:0]  s_payload_len = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_forward;
    logic [2:0]  m_status;
    logic [31:0] m_byte_total;
    logic [8:0]  m_led_period_ms;
    logic [3:0]  m_led_flashes;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_addr = '0;
    logic [31:0] cfg_data = '0;

    meter_list_filter_rate_limiter uut (.*);

    frame_word_t pending_words[$];
    verdict_t    verdicts[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          stall_mode = 0;

    logic        mir_filter = 1'b0;
    logic        mir_drop = 1'b0;
    logic        mir_rate = 1'b0;
    logic [15:0] mir_ival = '0;
    logic [1:0]  mir_count = '0;
    logic [31:0] mir_list [3];
    logic [31:0] trk_id [TABLE_DEPTH];
    logic [31:0] trk_time [TABLE_DEPTH];
    logic        trk_used [TABLE_DEPTH];
    logic [31:0] byte_sum = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("meter_list_filter_rate_limiter verification failed");
            $finish;
        end
    end

    function automatic void count_bytes(input logic [7:0] n);
        logic [32:0] sum;
        sum = {1'b0, byte_sum} + {25'd0, n};
        byte_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // interval stage against the table of last forward times
    function automatic logic [2:0] pace_meter(input logic [31:0] id, input logic [31:0] now);
        int          free_idx;
        logic [31:0] elapsed;
        free_idx = -1;
        if (!mir_rate) return STAT_FORWARDED;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (trk_used[i]) begin
                if (trk_id[i] == id) begin
                    elapsed = now - trk_time[i];
                    if (elapsed < {16'd0, mir_ival}) return STAT_RATELIMIT;
                    trk_time[i] = now;
                    return STAT_FORWARDED;
                end
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (free_idx < 0) return STAT_UNTRACKED;
        trk_id[free_idx]   = id;
        trk_time[free_idx] = now;
        trk_used[free_idx] = 1'b1;
        return STAT_FORWARDED;
    endfunction

    task automatic judge_word(input frame_word_t w);
        verdict_t   v;
        logic [2:0] st;
        logic       listed;
        v.forward       = 1'b0;
        v.status        = STAT_FORWARDED;
        v.byte_total    = '0;
        v.led_period_ms = '0;
        v.led_flashes   = '0;
        if (w.opcode == OP_TICK) begin
            v.status     = STAT_TICK;
            v.byte_total = byte_sum;
            if (byte_sum == 0) begin
                v.led_period_ms = '0;
            end else if (byte_sum < LED_LIMIT_LO) begin
                v.led_period_ms = LED_PERIOD_SLOW;
                v.led_flashes   = LED_FLASH_FEW;
            end else if (byte_sum < LED_LIMIT_HI) begin
                v.led_period_ms = LED_PERIOD_MID;
                v.led_flashes   = LED_FLASH_MID;
            end else begin
                v.led_period_ms = LED_PERIOD_FAST;
                v.led_flashes   = LED_FLASH_MANY;
            end
            byte_sum = '0;
        end else begin
            listed = 1'b0;
            for (int i = 0; i < 3; i++) begin
                if (i < mir_count && mir_list[i] == w.meter_id) listed = 1'b1;
            end
            if (!mir_filter) begin
                count_bytes(w.payload_len);
                st = STAT_FORWARDED;
            end else if (listed) begin
                if (!mir_drop) begin
                    st = pace_meter(w.meter_id, w.now_seconds);
                    if (st != STAT_RATELIMIT) count_bytes(w.payload_len);
                end else begin
                    st = STAT_LISTBLOCK;
                end
            end else if (mir_drop) begin
                count_bytes(w.payload_len);
                st = pace_meter(w.meter_id, w.now_seconds);
            end else begin
                st = STAT_LISTBLOCK;
            end
            v.status  = st;
            v.forward = (st == STAT_FORWARDED || st == STAT_UNTRACKED);
        end
        verdicts.push_back(v);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (addr)
            CFG_FILTER_EN:  mir_filter  = data[0];
            CFG_DROP_MODE:  mir_drop    = data[0];
            CFG_RATE_EN:    mir_rate    = data[0];
            CFG_MIN_IVAL:   mir_ival    = data[15:0];
            CFG_LIST_COUNT: mir_count   = data[1:0];
            CFG_LIST_ID_A:  mir_list[0] = data;
            CFG_LIST_ID_B:  mir_list[1] = data;
            CFG_LIST_ID_C:  mir_list[2] = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_word(input logic op, input logic [31:0] id, input logic [31:0] now,
                              input logic [7:0] len);
        frame_word_t w;
        w.opcode      = op;
        w.meter_id    = id;
        w.now_seconds = now;
        w.payload_len = len;
        pending_words.push_back(w);
    endtask

    task automatic queue_tick();
        queue_word(OP_TICK, $urandom(), $urandom(), 8'($urandom()));
    endtask

    // hold until every word went out and every result came back
    task automatic await_drain();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || verdicts.size() != 0);
    endtask

    frame_word_t on_wire;
    int          burst_left = 0;
    int          gap_left = 0;

    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) judge_word(on_wire);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    on_wire = pending_words.pop_front();
                    s_valid       <= 1'b1;
                    s_opcode      <= on_wire.opcode;
                    s_meter_id    <= on_wire.meter_id;
                    s_now_seconds <= on_wire.now_seconds;
                    s_payload_len <= on_wire.payload_len;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                  : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    int stall_left = 0;

    always @(posedge aclk) begin : monitor
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdicts.size() == 0) begin
                    $error("result word with no prediction pending");
                    fail_count++;
                end else begin
                    want = verdicts.pop_front();
                    if (m_forward !== want.forward) begin
                        $error("forward: expected %0d, got %0d", want.forward, m_forward);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_byte_total !== want.byte_total) begin
                        $error("byte_total: expected %0d, got %0d", want.byte_total,
                               m_byte_total);
                        fail_count++;
                    end
                    if (m_led_period_ms !== want.led_period_ms) begin
                        $error("led_period_ms: expected %0d, got %0d", want.led_period_ms,
                               m_led_period_ms);
                        fail_count++;
                    end
                    if (m_led_flashes !== want.led_flashes) begin
                        $error("led_flashes: expected %0d, got %0d", want.led_flashes,
                               m_led_flashes);
                        fail_count++;
                    end
                end
            end
            if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (cycle_count % 4 == 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_ready <= 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(5, 30);
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    initial begin : stimulus
        logic [31:0] pool [POOL_SIZE];
        logic [31:0] clock_s;
        logic [31:0] id;
        int          span;
        int          pick;
        int          ival;

        for (int i = 0; i < TABLE_DEPTH; i++) begin
            trk_id[i]   = '0;
            trk_time[i] = '0;
            trk_used[i] = 1'b0;
        end
        for (int k = 0; k < 3; k++) mir_list[k] = '0;
        for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // filter off: forward all, LED limits at their edges, empty tick
        @(negedge aclk);
        queue_word(OP_FRAME, 32'h0, 32'h0, 8'd0);
        queue_word(OP_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        queue_tick();
        queue_tick();
        queue_word(OP_FRAME, 32'd1, 32'd1, 8'd127);
        queue_tick();
        queue_word(OP_FRAME, 32'd1, 32'd2, 8'd128);
        queue_tick();
        queue_word(OP_FRAME, 32'd2, 32'd3, 8'd255);
        queue_word(OP_FRAME, 32'd2, 32'd4, 8'd255);
        queue_word(OP_FRAME, 32'd2, 32'd5, 8'd1);
        queue_tick();
        queue_word(OP_FRAME, 32'd3, 32'd6, 8'd255);
        queue_word(OP_FRAME, 32'd3, 32'd7, 8'd255);
        queue_word(OP_FRAME, 32'd3, 32'd8, 8'd2);
        queue_tick();
        await_drain();

        // accept mode with the interval check, list ids at the extremes
        write_reg(CFG_FILTER_EN, 32'd1);
        write_reg(CFG_DROP_MODE, 32'd0);
        write_reg(CFG_RATE_EN, 32'd1);
        write_reg(CFG_MIN_IVAL, 32'd5);
        write_reg(CFG_LIST_COUNT, 32'd3);
        write_reg(CFG_LIST_ID_A, 32'h0);
        write_reg(CFG_LIST_ID_B, 32'hFFFF_FFFF);
        write_reg(CFG_LIST_ID_C, 32'h1234_5678);
        for (int k = 1; k <= 8; k++) write_reg(4'(CFG_LIST_ID_C + k), $urandom());
        @(negedge aclk);
        queue_word(OP_FRAME, 32'h0, 32'd100, 8'd10);
        queue_word(OP_FRAME, 32'h0, 32'd104, 8'd10);
        queue_word(OP_FRAME, 32'h0, 32'd105, 8'd10);
        queue_word(OP_FRAME, 32'd7, 32'd106, 8'd10);
        queue_word(OP_FRAME, 32'hFFFF_FFFF, 32'd3, 8'd20);
        queue_tick();
        await_drain();

        // drop mode: bytes counted ahead of the interval check, time wrap
        write_reg(CFG_DROP_MODE, 32'd1);
        write_reg(CFG_LIST_COUNT, 32'd1);
        write_reg(CFG_LIST_ID_A, 32'h1234_5678);
        @(negedge aclk);
        queue_word(OP_FRAME, 32'h1234_5678, 32'd9, 8'd40);
        queue_word(OP_FRAME, 32'd99, 32'd10, 8'd50);
        queue_word(OP_FRAME, 32'd99, 32'd11, 8'd60);
        queue_tick();
        queue_word(OP_FRAME, 32'd99, 32'hFFFF_FFFF, 8'd1);
        queue_word(OP_FRAME, 32'd99, 32'd2, 8'd1);
        await_drain();

        clock_s = $urandom();
        for (int p = 0; p < PHASES; p++) begin
            span = (p < 6) ? 10 : POOL_SIZE;
            ival = (p == 1) ? 0 : (p == 3) ? 65535 : $urandom_range(1, 12);
            write_reg(CFG_FILTER_EN, (p != 0 && $urandom_range(0, 5) != 0) ? 32'd1 : 32'd0);
            write_reg(CFG_DROP_MODE, (p % 2 == 1) ? 32'd1 : 32'd0);
            write_reg(CFG_RATE_EN, (p % 3 != 2) ? 32'd1 : 32'd0);
            write_reg(CFG_MIN_IVAL, 32'(ival));
            write_reg(CFG_LIST_COUNT, 32'(p % 4));
            for (int k = 0; k < 3; k++) begin
                if (p == 5) id = (k == 0) ? 32'h0 : 32'hFFFF_FFFF;
                else id = pool[$urandom_range(0, span - 1)];
                write_reg(4'(CFG_LIST_ID_A + k), id);
            end
            if (p == 7) clock_s = 32'hFFFF_FFC0;
            for (int c = 0; c < 2; c++) begin
                @(negedge aclk);
                for (int n = 0; n < RANDOM_ITEMS / PHASES / 2; n++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        queue_tick();
                    end else begin
                        if ($urandom_range(0, 19) == 0) clock_s = $urandom();
                        else clock_s = clock_s + $urandom_range(0, 4);
                        pick = $urandom_range(0, 15);
                        if (pick == 0 && p >= 6) id = $urandom();
                        else if (pick >= 1 && pick <= 5) id = mir_list[pick % 3];
                        else id = pool[$urandom_range(0, span - 1)];
                        queue_word(OP_FRAME, id, clock_s, 8'($urandom_range(0, 255)));
                    end
                end
                await_drain();
            end
        end

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && verdicts.size() == 0) begin
            $display("meter_list_filter_rate_limiter verification clean");
        end else begin
            $display("meter_list_filter_rate_limiter verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mlf_pkg.sv
rtl/mlf_cell.sv
rtl/mlf_chain.sv
rtl/meter_list_filter_rate_limiter.sv
bench/tb_meter_list_filter_rate_limiter.sv
